/* rtl/stbs_pkg.sv */
package stbs_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int PTR_W       = $clog2(TABLE_DEPTH + 1);
	localparam int VALUE_W     = 32;
	localparam int INDEX_W     = 10;
	localparam int COUNT_W     = 11;
	localparam int COMP_W      = 5;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic wr;
		logic load;
		logic rd;
		logic step;
		logic publish;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic equal;
		logic out_free;
	} dp_status_t;

endpackage

/* rtl/stbs_ram.sv */
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

/* rtl/stbs_ctrl.sv */
module stbs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 request_valid,
	input  logic                 operation,
	output logic                 request_stall,
	input  stbs_pkg::dp_status_t status,
	output stbs_pkg::dp_cmd_t    cmd
);

	stbs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stbs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			stbs_pkg::ST_IDLE: begin
				if (request_valid && operation == stbs_pkg::OP_SEARCH) begin
					state_d = stbs_pkg::ST_READ;
				end
			end
			stbs_pkg::ST_READ: begin
				state_d = status.empty ? stbs_pkg::ST_DONE : stbs_pkg::ST_CMP;
			end
			stbs_pkg::ST_CMP: begin
				state_d = status.equal ? stbs_pkg::ST_DONE : stbs_pkg::ST_READ;
			end
			stbs_pkg::ST_DONE: begin
				if (status.out_free) begin
					state_d = stbs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = stbs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		request_stall = 1'b1;
		cmd           = '0;
		case (state_q)
			stbs_pkg::ST_IDLE: begin
				request_stall = 1'b0;
				cmd.wr   = request_valid && operation == stbs_pkg::OP_WRITE;
				cmd.load = request_valid && operation == stbs_pkg::OP_SEARCH;
			end
			stbs_pkg::ST_READ: begin
				cmd.rd = !status.empty;
			end
			stbs_pkg::ST_CMP: begin
				cmd.step = 1'b1;
			end
			stbs_pkg::ST_DONE: begin
				cmd.publish = status.out_free;
			end
			default: begin
				request_stall = 1'b1;
			end
		endcase
	end

	// compare always follows its read
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == stbs_pkg::ST_CMP |-> $past(state_q) == stbs_pkg::ST_READ)
		else $error("compare without read");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> state_q == stbs_pkg::ST_IDLE)
		else $error("publish did not end search");

endmodule

/* rtl/stbs_dp.sv */
module stbs_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  stbs_pkg::dp_cmd_t             cmd,
	output stbs_pkg::dp_status_t          status,
	input  logic                          cfg_valid,
	input  logic [stbs_pkg::COUNT_W-1:0]  cfg_data,
	input  logic [stbs_pkg::INDEX_W-1:0]  entry_index,
	input  logic signed [stbs_pkg::VALUE_W-1:0] entry_value,
	input  logic signed [stbs_pkg::VALUE_W-1:0] search_key,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          found,
	output logic [stbs_pkg::INDEX_W-1:0]  match_index,
	output logic [stbs_pkg::COMP_W-1:0]   comparison_count
);

	logic [stbs_pkg::COUNT_W-1:0] table_count_q;
	logic [stbs_pkg::PTR_W-1:0]   count_lim;
	logic [stbs_pkg::PTR_W-1:0]   lo_q, hi_q, diff, mid;
	logic signed [stbs_pkg::VALUE_W-1:0] key_q;
	logic signed [stbs_pkg::VALUE_W-1:0] rdata;
	logic [stbs_pkg::COMP_W-1:0]  comps_q;
	logic                         hit_q;
	logic [stbs_pkg::ADDR_W-1:0]  where_q;
	logic                         wr_ok;
	logic [stbs_pkg::ADDR_W-1:0]  ram_addr;
	logic                         less, equal;
	logic                         result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_count_q <= '0;
		end else if (cfg_valid) begin
			table_count_q <= cfg_data;
		end
	end

	assign count_lim = (table_count_q > stbs_pkg::TABLE_DEPTH)
		? stbs_pkg::PTR_W'(stbs_pkg::TABLE_DEPTH)
		: stbs_pkg::PTR_W'(table_count_q);

	// hi_q is one past the last live index
	assign diff = hi_q - lo_q - stbs_pkg::PTR_W'(1);
	assign mid  = lo_q + (diff >> 1);

	assign wr_ok    = cmd.wr && (32'(entry_index) < stbs_pkg::TABLE_DEPTH);
	assign ram_addr = cmd.wr ? stbs_pkg::ADDR_W'(entry_index) : mid[stbs_pkg::ADDR_W-1:0];

	stbs_ram #(
		.WIDTH(stbs_pkg::VALUE_W),
		.DEPTH(stbs_pkg::TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.en   (wr_ok || cmd.rd),
		.we   (wr_ok),
		.addr (ram_addr),
		.wdata(entry_value),
		.rdata(rdata)
	);

	assign less  = rdata < key_q;
	assign equal = rdata == key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= '0;
			hi_q <= '0;
		end else if (cmd.load) begin
			lo_q <= '0;
			hi_q <= count_lim;
		end else if (cmd.step) begin
			if (less) begin
				lo_q <= mid + stbs_pkg::PTR_W'(1);
			end else if (!equal) begin
				hi_q <= mid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q   <= search_key;
			comps_q <= '0;
			hit_q   <= 1'b0;
			where_q <= '0;
		end else if (cmd.step) begin
			comps_q <= comps_q + (less ? stbs_pkg::COMP_W'(1) : stbs_pkg::COMP_W'(2));
			if (equal) begin
				hit_q   <= 1'b1;
				where_q <= mid[stbs_pkg::ADDR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			found            <= hit_q;
			match_index      <= stbs_pkg::INDEX_W'(where_q);
			comparison_count <= comps_q;
		end
	end

	assign result_valid    = result_valid_q;
	assign status.empty    = lo_q >= hi_q;
	assign status.equal    = equal;
	assign status.out_free = !result_valid_q || !result_stall;

	assert property (@(posedge clk) disable iff (!arst_n) lo_q <= hi_q)
		else $error("search range inverted");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && found |-> comparison_count >= stbs_pkg::COMP_W'(2))
		else $error("hit with too few comparisons");

endmodule

/* rtl/sorted_table_binary_search.sv */
// Sorted table binary search.
// Request channel (request_valid / request_stall): operation 0 writes
// entry_value at entry_index (indexes past the table are dropped, no
// result); operation 1 searches for search_key and gives one result.
// Result channel (result_valid / result_stall): found, match_index and
// comparison_count. The result is held in an output register until taken.
// Config channel (cfg_valid / cfg_ready, always ready): cfg_data sets the
// number of table entries in use; write it only while the block is idle.
// Each probe of a search is a registered read of the single-port table
// RAM followed by a compare step.
// The block works on one search at a time; request_stall is high from the
// cycle after a search is taken until its result is loaded into the
// output register, which waits while a previous result is still stalled.
// Reset clears the entry count to zero and all control state; the table
// contents are not cleared and must be written before they are searched.
module sorted_table_binary_search (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [stbs_pkg::COUNT_W-1:0]       cfg_data,
	input  logic                               request_valid,
	output logic                               request_stall,
	input  logic                               operation,
	input  logic [stbs_pkg::INDEX_W-1:0]       entry_index,
	input  logic signed [stbs_pkg::VALUE_W-1:0] entry_value,
	input  logic signed [stbs_pkg::VALUE_W-1:0] search_key,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic                               found,
	output logic [stbs_pkg::INDEX_W-1:0]       match_index,
	output logic [stbs_pkg::COMP_W-1:0]        comparison_count
);

	stbs_pkg::dp_cmd_t    cmd;
	stbs_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	stbs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.request_valid(request_valid),
		.operation    (operation),
		.request_stall(request_stall),
		.status       (status),
		.cmd          (cmd)
	);

	stbs_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_valid       (cfg_valid),
		.cfg_data        (cfg_data),
		.entry_index     (entry_index),
		.entry_value     (entry_value),
		.search_key      (search_key),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.found           (found),
		.match_index     (match_index),
		.comparison_count(comparison_count)
	);

endmodule
